// ===== src/kprq_pkg.sv =====
package kprq_pkg;

	localparam int KEY_COUNT = 256;
	localparam int KEY_BITS  = $clog2(KEY_COUNT);
	localparam int TIME_BITS = 32;
	localparam int DUR_BITS  = 16;
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [DUR_BITS-1:0] HOLD_RST       = 16'd500;
	localparam logic [DUR_BITS-1:0] INTERVAL_RST   = 16'd100;
	localparam logic [DUR_BITS-1:0] REP_DELAY_RST  = 16'd400;
	localparam logic [DUR_BITS-1:0] REP_PERIOD_RST = 16'd80;

	typedef enum logic [2:0] {
		ACT_PRESS   = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_HOLD    = 3'd2,
		ACT_IVL_A   = 3'd3,
		ACT_IVL_B   = 3'd4,
		ACT_CDR     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		REG_HOLD       = 2'd0,
		REG_INTERVAL   = 2'd1,
		REG_REP_DELAY  = 2'd2,
		REG_REP_PERIOD = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DUR_BITS-1:0] hold;
		logic [DUR_BITS-1:0] interval;
		logic [DUR_BITS-1:0] rep_delay;
		logic [DUR_BITS-1:0] rep_period;
	} cfg_t;

	// per-key record kept in the state memory
	typedef struct packed {
		logic                 level_flag;
		logic [TIME_BITS-1:0] hold_start;
		logic                 hold_active;
		logic                 hold_fired;
		logic [TIME_BITS-1:0] ia_time;
		logic                 ia_active;
		logic [TIME_BITS-1:0] ib_time;
		logic                 ib_active;
		logic [TIME_BITS-1:0] rep_start;
		logic                 rep_active;
	} key_rec_t;

	typedef struct packed {
		logic                en;
		logic [KEY_BITS-1:0] key;
		key_rec_t            rec;
	} wr_req_t;

	function automatic logic reached(input logic [TIME_BITS-1:0] now,
		input logic [TIME_BITS-1:0] since, input logic [DUR_BITS-1:0] span);
		logic [TIME_BITS-1:0] diff;
		diff = now - since;
		return diff >= TIME_BITS'(span);
	endfunction

endpackage

// ===== src/kprq_regs.sv =====
module kprq_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kprq_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [kprq_pkg::DATA_BITS-1:0]     pwdata,
	output logic [kprq_pkg::DATA_BITS-1:0]     prdata,
	output logic                               pready,
	output kprq_pkg::cfg_t                     cfg
);
	import kprq_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold       <= HOLD_RST;
			cfg_q.interval   <= INTERVAL_RST;
			cfg_q.rep_delay  <= REP_DELAY_RST;
			cfg_q.rep_period <= REP_PERIOD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HOLD:       cfg_q.hold       <= pwdata[DUR_BITS-1:0];
				REG_INTERVAL:   cfg_q.interval   <= pwdata[DUR_BITS-1:0];
				REG_REP_DELAY:  cfg_q.rep_delay  <= pwdata[DUR_BITS-1:0];
				REG_REP_PERIOD: cfg_q.rep_period <= pwdata[DUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HOLD:       prdata = DATA_BITS'(cfg_q.hold);
			REG_INTERVAL:   prdata = DATA_BITS'(cfg_q.interval);
			REG_REP_DELAY:  prdata = DATA_BITS'(cfg_q.rep_delay);
			REG_REP_PERIOD: prdata = DATA_BITS'(cfg_q.rep_period);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== src/kprq_store.sv =====
module kprq_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [kprq_pkg::KEY_BITS-1:0] rd_key,
	input  kprq_pkg::wr_req_t             wr,
	output kprq_pkg::key_rec_t            rd_rec
);
	import kprq_pkg::*;

	key_rec_t                mem [KEY_COUNT];
	key_rec_t                rdata_q;
	logic [KEY_COUNT-1:0]    written_q;
	logic [KEY_BITS-1:0]     rd_key_q;
	logic                    fwd_q;
	key_rec_t                fwd_rec_q;

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_key];
		if (wr.en)
			mem[wr.key] <= wr.rec;
	end

	// entries never written read as the all-zero reset record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_key_q  <= '0;
			fwd_q     <= 1'b0;
		end else begin
			if (wr.en)
				written_q[wr.key] <= 1'b1;
			if (rd_en) begin
				rd_key_q <= rd_key;
				fwd_q    <= wr.en && (wr.key == rd_key);
			end
		end
	end

	// read and write to the same key on one edge: memory returns old data
	always_ff @(posedge clk) begin
		if (rd_en && wr.en)
			fwd_rec_q <= wr.rec;
	end

	always_comb begin
		if (fwd_q)
			rd_rec = fwd_rec_q;
		else if (written_q[rd_key_q])
			rd_rec = rdata_q;
		else
			rd_rec = '0;
	end

endmodule

// ===== src/kprq_eval.sv =====
module kprq_eval (
	input  logic [2:0]                     action,
	input  logic                           down,
	input  logic [kprq_pkg::TIME_BITS-1:0] now,
	input  kprq_pkg::cfg_t                 cfg,
	input  kprq_pkg::key_rec_t             rec,
	output kprq_pkg::key_rec_t             nxt,
	output logic                           fire
);
	import kprq_pkg::*;

	logic [TIME_BITS-1:0] hold_base;
	logic                 hold_done;

	assign hold_base = rec.hold_active ? rec.hold_start : now;
	assign hold_done = rec.hold_active && rec.hold_fired;

	always_comb begin
		nxt  = rec;
		fire = 1'b0;
		case (action)
			ACT_PRESS: begin
				if (down && !rec.level_flag) begin
					nxt.level_flag = 1'b1;
					fire = 1'b1;
				end else if (!down) begin
					nxt.level_flag = 1'b0;
				end
			end
			ACT_RELEASE: begin
				if (!down && rec.level_flag) begin
					nxt.level_flag = 1'b0;
					fire = 1'b1;
				end else if (down) begin
					nxt.level_flag = 1'b1;
				end
			end
			ACT_HOLD: begin
				if (!down) begin
					nxt.hold_start  = '0;
					nxt.hold_active = 1'b0;
					nxt.hold_fired  = 1'b0;
				end else begin
					nxt.hold_start  = hold_base;
					nxt.hold_active = 1'b1;
					nxt.hold_fired  = hold_done;
					if (!hold_done && reached(now, hold_base, cfg.hold)) begin
						nxt.hold_fired = 1'b1;
						fire = 1'b1;
					end
				end
			end
			ACT_IVL_A: begin
				if (!down) begin
					nxt.ia_time   = '0;
					nxt.ia_active = 1'b0;
				end else if (!rec.ia_active || reached(now, rec.ia_time, cfg.interval)) begin
					nxt.ia_time   = now;
					nxt.ia_active = 1'b1;
					fire = 1'b1;
				end
			end
			ACT_IVL_B: begin
				if (!down) begin
					nxt.ib_time   = '0;
					nxt.ib_active = 1'b0;
				end else if (!rec.ib_active || reached(now, rec.ib_time, cfg.interval)) begin
					nxt.ib_time   = now;
					nxt.ib_active = 1'b1;
					fire = 1'b1;
				end
			end
			ACT_CDR: begin
				if (!down) begin
					nxt.level_flag = 1'b0;
					nxt.ib_time    = '0;
					nxt.ib_active  = 1'b0;
					nxt.rep_start  = '0;
					nxt.rep_active = 1'b0;
				end else if (!rec.level_flag) begin
					nxt.level_flag = 1'b1;
					nxt.ib_time    = now;
					nxt.ib_active  = 1'b1;
					nxt.rep_start  = '0;
					nxt.rep_active = 1'b0;
					fire = 1'b1;
				end else if (!rec.rep_active) begin
					// delay phase counts from the click time held in the B timer
					if (reached(now, rec.ib_time, cfg.rep_delay)) begin
						nxt.rep_start  = now;
						nxt.rep_active = 1'b1;
						fire = 1'b1;
					end
				end else if (reached(now, rec.rep_start, cfg.rep_period)) begin
					nxt.rep_start = now;
					fire = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/key_press_repeat_qualifier.sv =====
// Per-key press qualifier with typematic repeat for 256 key codes.
// Item channel (item_valid/item_ready): action, key_code, key_down, now_ms.
// Result channel (result_valid/result_ready): one fire bit per item, in order.
// Settings sit in four 16-bit APB registers at byte addresses 0, 4, 8, 12:
// hold, interval, repeat delay, repeat period. Write them only while idle.
// A taken item moves through the update stage and then the output register.
// Throughput: one item per cycle unless a stall holds the output. Each item
// does one read-modify-write of its key's record in a state RAM with one read
// and one write port; the read is issued at acceptance, the update is written
// back when the item moves into the output register.
// A record written on the same edge that the next item reads is forwarded.
// Reset: all keys read as idle records through per-key written bits, which
// clear at once, so items can be taken as soon as reset is released.
// Registers return to 500, 100, 400 and 80 ms.
// Stall: with result_ready low, one item waits in the output register and one
// in the update stage; item_ready then drops until the output drains.
module key_press_repeat_qualifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kprq_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [kprq_pkg::DATA_BITS-1:0]     pwdata,
	output logic [kprq_pkg::DATA_BITS-1:0]     prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [2:0]                         action,
	input  logic [kprq_pkg::KEY_BITS-1:0]      key_code,
	input  logic                               key_down,
	input  logic [kprq_pkg::TIME_BITS-1:0]     now_ms,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               fire
);
	import kprq_pkg::*;

	cfg_t                 cfg;
	logic                 in_acc;
	logic                 adv;
	logic                 valid_s1;
	logic [2:0]           action_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic                 down_s1;
	logic [TIME_BITS-1:0] now_s1;
	key_rec_t             rec;
	key_rec_t             nxt;
	logic                 fire_c;
	wr_req_t              wr;
	logic                 out_valid_q;
	logic                 fire_q;

	kprq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv        = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;
	assign in_acc     = item_valid && item_ready;

	assign wr.en  = adv;
	assign wr.key = key_s1;
	assign wr.rec = nxt;

	kprq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_key (key_code),
		.wr     (wr),
		.rd_rec (rec)
	);

	kprq_eval u_eval (
		.action (action_s1),
		.down   (down_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.rec    (rec),
		.nxt    (nxt),
		.fire   (fire_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1 <= action;
			key_s1    <= key_code;
			down_s1   <= key_down;
			now_s1    <= now_ms;
		end
		if (adv)
			fire_q <= fire_c;
	end

	assign result_valid = out_valid_q;
	assign fire         = fire_q;

	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted transaction did not reach update stage");

	a_wr_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> valid_s1)
		else $error("state write without an item in update stage");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result_ready) |-> !item_ready)
		else $error("item taken while both stages are held");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("write-back without a result");

endmodule
